FILE: rtl/aabb_platform_collision_resolver_top_defines.svh
// assertion macros for the platform collision resolver
// expects clk and arst_n in the scope of every use
`ifndef AABB_PLATFORM_COLLISION_RESOLVER_TOP_DEFINES_SVH
`define AABB_PLATFORM_COLLISION_RESOLVER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define APCR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("apcr assertion failed");
`define APCR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("apcr assertion failed");
`else
`define APCR_ASSERT_IMP(lbl, ante, cons)
`define APCR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/apcr_pkg.sv
// shared types and constants of the platform collision resolver
// no dependencies
`default_nettype none
package apcr_pkg;
	localparam int DEF_MAX_PLATFORMS = 64;
	localparam int IDX_W = 6;
	localparam int SLOTS = 2 ** IDX_W;
	localparam int POS_W = 20;
	localparam int SIZE_W = 19;
	localparam int COR_W = 21;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIFF,
		ST_OVL,
		ST_RSLT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [POS_W-1:0] left;
		logic signed [POS_W-1:0] top;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} geo_t;

	typedef struct packed {
		logic wr;
		logic start_query;
		logic scan;
		logic take_hit;
		logic calc_diff;
		logic calc_ov;
		logic calc_res;
		logic clr_res;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic hit_s1;
		logic end_s1;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

FILE: rtl/apcr_datapath.sv
// platform table, scan pipeline, push-out arithmetic and output register
// depends on apcr_pkg and the assertion macro header
`default_nettype none
`include "aabb_platform_collision_resolver_top_defines.svh"
module apcr_datapath #(
	parameter int MAX_PLATFORMS = apcr_pkg::DEF_MAX_PLATFORMS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire apcr_pkg::cmd_t cmd,
	output apcr_pkg::sts_t sts,
	input  wire logic [apcr_pkg::IDX_W-1:0] entry_index,
	input  wire logic signed [apcr_pkg::POS_W-1:0] entry_x,
	input  wire logic signed [apcr_pkg::POS_W-1:0] entry_y,
	input  wire logic [apcr_pkg::SIZE_W-1:0] entry_w,
	input  wire logic [apcr_pkg::SIZE_W-1:0] entry_h,
	input  wire logic entry_solid,
	input  wire logic signed [apcr_pkg::POS_W-1:0] obj_x,
	input  wire logic signed [apcr_pkg::POS_W-1:0] obj_y,
	input  wire logic [apcr_pkg::SIZE_W-1:0] obj_w,
	input  wire logic [apcr_pkg::SIZE_W-1:0] obj_h,
	output logic out_valid,
	input  wire logic out_stall,
	output logic hit,
	output logic [apcr_pkg::IDX_W-1:0] hit_index,
	output logic signed [apcr_pkg::COR_W-1:0] correction_x,
	output logic signed [apcr_pkg::COR_W-1:0] correction_y
);
	// slots above the entry index range can never be written
	localparam int DEPTH = (MAX_PLATFORMS < apcr_pkg::SLOTS) ?
		MAX_PLATFORMS : apcr_pkg::SLOTS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [apcr_pkg::IDX_W:0] DEPTH_W = (apcr_pkg::IDX_W + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

	apcr_pkg::geo_t mem [DEPTH];
	logic [DEPTH-1:0] solid_q;

	logic wr_ok;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] rd_cnt_q;
	logic rd_issue;

	apcr_pkg::geo_t geo_s1;
	logic solid_s1;
	logic vld_s1;
	logic [AW-1:0] idx_s1;

	logic signed [apcr_pkg::POS_W-1:0] obj_x_q, obj_y_q;
	logic [apcr_pkg::SIZE_W-1:0] obj_w_q, obj_h_q;

	apcr_pkg::geo_t hgeo_q;
	logic [AW-1:0] hidx_q;
	logic signed [22:0] dx_q, dy_q;
	logic signed [23:0] ovx_q, ovy_q;

	logic res_hit_q;
	logic [apcr_pkg::IDX_W-1:0] res_idx_q;
	logic signed [apcr_pkg::COR_W-1:0] res_cx_q, res_cy_q;
	logic out_vld_q;

	// edge tests on 21-bit signed values
	logic signed [20:0] o_l, o_t, o_r, o_b, p_l, p_t, p_r, p_b;
	logic overlap;

	logic signed [22:0] ocx, ocy, pcx, pcy;
	logic signed [22:0] adx, ady;
	logic signed [23:0] sumw, sumh;
	logic signed [23:0] neg_ovx, neg_ovy;

	assign wr_ok = cmd.wr && ({1'b0, entry_index} < DEPTH_W);
	assign wr_addr = entry_index[AW-1:0];
	assign rd_issue = cmd.scan && (rd_cnt_q < DEPTH_C);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_addr] <= '{left: entry_x, top: entry_y, width: entry_w, height: entry_h};
		end
		if (rd_issue) begin
			geo_s1 <= mem[rd_cnt_q[AW-1:0]];
			solid_s1 <= solid_q[rd_cnt_q[AW-1:0]];
			idx_s1 <= rd_cnt_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solid_q <= '0;
			rd_cnt_q <= '0;
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (wr_ok) begin
				solid_q[wr_addr] <= entry_solid;
			end
			if (cmd.start_query) begin
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			vld_s1 <= rd_issue;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		o_l = {obj_x_q[19], obj_x_q};
		o_t = {obj_y_q[19], obj_y_q};
		o_r = o_l + {2'b00, obj_w_q};
		o_b = o_t + {2'b00, obj_h_q};
		p_l = {geo_s1.left[19], geo_s1.left};
		p_t = {geo_s1.top[19], geo_s1.top};
		p_r = p_l + {2'b00, geo_s1.width};
		p_b = p_t + {2'b00, geo_s1.height};
		overlap = !(o_l >= p_r || o_r <= p_l || o_t >= p_b || o_b <= p_t);
	end

	assign sts.hit_s1 = vld_s1 && solid_s1 && overlap;
	assign sts.end_s1 = vld_s1 && (idx_s1 == LAST_A);
	assign sts.out_free = !out_vld_q || !out_stall;

	// doubled centers, one more fractional bit
	always_comb begin
		ocx = {{2{obj_x_q[19]}}, obj_x_q, 1'b0} + {4'b0000, obj_w_q};
		ocy = {{2{obj_y_q[19]}}, obj_y_q, 1'b0} + {4'b0000, obj_h_q};
		pcx = {{2{hgeo_q.left[19]}}, hgeo_q.left, 1'b0} + {4'b0000, hgeo_q.width};
		pcy = {{2{hgeo_q.top[19]}}, hgeo_q.top, 1'b0} + {4'b0000, hgeo_q.height};
		adx = dx_q[22] ? -dx_q : dx_q;
		ady = dy_q[22] ? -dy_q : dy_q;
		sumw = {5'b00000, obj_w_q} + {5'b00000, hgeo_q.width};
		sumh = {5'b00000, obj_h_q} + {5'b00000, hgeo_q.height};
		neg_ovx = -ovx_q;
		neg_ovy = -ovy_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			obj_x_q <= obj_x;
			obj_y_q <= obj_y;
			obj_w_q <= obj_w;
			obj_h_q <= obj_h;
		end
		if (cmd.take_hit) begin
			hgeo_q <= geo_s1;
			hidx_q <= idx_s1;
		end
		if (cmd.calc_diff) begin
			dx_q <= ocx - pcx;
			dy_q <= ocy - pcy;
		end
		if (cmd.calc_ov) begin
			ovx_q <= sumw - {adx[22], adx};
			ovy_q <= sumh - {ady[22], ady};
		end
		priority if (cmd.clr_res) begin
			res_hit_q <= 1'b0;
			res_idx_q <= '0;
			res_cx_q <= '0;
			res_cy_q <= '0;
		end else if (cmd.calc_res) begin
			res_hit_q <= 1'b1;
			res_idx_q <= apcr_pkg::IDX_W'(hidx_q);
			// tie goes to y, zero center difference pushes negative
			if (ovx_q < ovy_q) begin
				res_cx_q <= (!dx_q[22] && dx_q != 0) ? ovx_q[20:0] : neg_ovx[20:0];
				res_cy_q <= '0;
			end else begin
				res_cx_q <= '0;
				res_cy_q <= (!dy_q[22] && dy_q != 0) ? ovy_q[20:0] : neg_ovy[20:0];
			end
		end
		if (cmd.load_out) begin
			hit <= res_hit_q;
			hit_index <= res_idx_q;
			correction_x <= res_cx_q;
			correction_y <= res_cy_q;
		end
	end

	assign out_valid = out_vld_q;

	`APCR_ASSERT_IMP(a_overlap_positive, cmd.calc_res, ovx_q > 0 && ovy_q > 0)
	`APCR_ASSERT_NXT(a_load_sets_valid, cmd.load_out, out_vld_q)
	`APCR_ASSERT_IMP(a_no_write_during_scan, cmd.wr, !cmd.scan && !vld_s1)
endmodule
`default_nettype wire

FILE: rtl/apcr_ctrl.sv
// sequencer of the platform collision resolver: accept, scan, arithmetic, output
// depends on apcr_pkg and the assertion macro header
`default_nettype none
`include "aabb_platform_collision_resolver_top_defines.svh"
module apcr_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic op,
	input  wire apcr_pkg::sts_t sts,
	output apcr_pkg::cmd_t cmd
);
	apcr_pkg::state_t state_q, state_d;
	logic accept;

	assign accept = in_valid && (state_q == apcr_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apcr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			apcr_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (op == apcr_pkg::OP_QUERY) ? apcr_pkg::ST_SCAN : apcr_pkg::ST_OUT;
				end
			end
			apcr_pkg::ST_SCAN: begin
				priority if (sts.hit_s1) begin
					state_d = apcr_pkg::ST_DIFF;
				end else if (sts.end_s1) begin
					state_d = apcr_pkg::ST_OUT;
				end
			end
			apcr_pkg::ST_DIFF: state_d = apcr_pkg::ST_OVL;
			apcr_pkg::ST_OVL: state_d = apcr_pkg::ST_RSLT;
			apcr_pkg::ST_RSLT: state_d = apcr_pkg::ST_OUT;
			apcr_pkg::ST_OUT: begin
				if (sts.out_free) begin
					state_d = apcr_pkg::ST_IDLE;
				end
			end
			default: state_d = apcr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			apcr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.wr = accept && (op == apcr_pkg::OP_WRITE);
				cmd.clr_res = accept && (op == apcr_pkg::OP_WRITE);
				cmd.start_query = accept && (op == apcr_pkg::OP_QUERY);
			end
			apcr_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				cmd.take_hit = sts.hit_s1;
				cmd.clr_res = !sts.hit_s1 && sts.end_s1;
			end
			apcr_pkg::ST_DIFF: cmd.calc_diff = 1'b1;
			apcr_pkg::ST_OVL: cmd.calc_ov = 1'b1;
			apcr_pkg::ST_RSLT: cmd.calc_res = 1'b1;
			apcr_pkg::ST_OUT: cmd.load_out = sts.out_free;
			default: cmd = '0;
		endcase
	end

	`APCR_ASSERT_IMP(a_load_when_free, cmd.load_out, sts.out_free)
	`APCR_ASSERT_NXT(a_hit_ends_scan, cmd.take_hit, state_q == apcr_pkg::ST_DIFF)
	`APCR_ASSERT_NXT(a_accept_leaves_idle, accept, state_q != apcr_pkg::ST_IDLE)
endmodule
`default_nettype wire

FILE: rtl/aabb_platform_collision_resolver_top.sv
// a write is stored on acceptance, then ST_OUT; a query scans to its first solid
// overlapping slot, then ST_DIFF, ST_OVL, ST_RSLT, ST_OUT; a miss scans all N slots,
// N the slot count (MAX_PLATFORMS, at most 64), then ST_OUT; one slot is read a cycle
// throughput: one item at a time, the next is taken once the result sits in the
// output register; reset clears all solid marks at once, no clearing pass
// top level: sequencer plus datapath with the platform table, needs apcr_pkg
`default_nettype none
module aabb_platform_collision_resolver_top #(
	parameter int MAX_PLATFORMS = apcr_pkg::DEF_MAX_PLATFORMS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic op,
	input  wire logic [apcr_pkg::IDX_W-1:0] entry_index,
	input  wire logic signed [apcr_pkg::POS_W-1:0] entry_x,
	input  wire logic signed [apcr_pkg::POS_W-1:0] entry_y,
	input  wire logic [apcr_pkg::SIZE_W-1:0] entry_w,
	input  wire logic [apcr_pkg::SIZE_W-1:0] entry_h,
	input  wire logic entry_solid,
	input  wire logic signed [apcr_pkg::POS_W-1:0] obj_x,
	input  wire logic signed [apcr_pkg::POS_W-1:0] obj_y,
	input  wire logic [apcr_pkg::SIZE_W-1:0] obj_w,
	input  wire logic [apcr_pkg::SIZE_W-1:0] obj_h,
	output logic out_valid,
	input  wire logic out_stall,
	output logic hit,
	output logic [apcr_pkg::IDX_W-1:0] hit_index,
	output logic signed [apcr_pkg::COR_W-1:0] correction_x,
	output logic signed [apcr_pkg::COR_W-1:0] correction_y
);
	apcr_pkg::cmd_t cmd;
	apcr_pkg::sts_t sts;

	apcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd)
	);

	apcr_datapath #(
		.MAX_PLATFORMS (MAX_PLATFORMS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.entry_index  (entry_index),
		.entry_x      (entry_x),
		.entry_y      (entry_y),
		.entry_w      (entry_w),
		.entry_h      (entry_h),
		.entry_solid  (entry_solid),
		.obj_x        (obj_x),
		.obj_y        (obj_y),
		.obj_w        (obj_w),
		.obj_h        (obj_h),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.hit_index    (hit_index),
		.correction_x (correction_x),
		.correction_y (correction_y)
	);
endmodule
`default_nettype wire
